// ===== rtl/core/kaf_pkg.sv =====
// ============================================================================
// kaf_pkg
// Shared widths and fixed-point helpers for the angle/bias Kalman filter.
// ============================================================================
package kaf_pkg;

    localparam int MulAW = 33;              // multiplier operand A
    localparam int MulBW = 36;              // multiplier operand B
    localparam int MulW  = MulAW + MulBW;   // full product
    localparam int NoiseW = 30;
    localparam int DivQW = 62;              // |P| * 2^30 fits in 62 bits
    localparam int DivCntW = 6;

    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic [NoiseW-1:0] ANGLE_NOISE_RST   = NoiseW'(107374);
    localparam logic [NoiseW-1:0] BIAS_NOISE_RST    = NoiseW'(429497);
    localparam logic [NoiseW-1:0] MEASURE_NOISE_RST = NoiseW'(4294967);

    // floor((v + 2^(s-1)) / 2^s)
    function automatic logic signed [MulW-1:0] rnd_shr(
        input logic signed [MulW-1:0] v,
        input int unsigned            s
    );
        logic signed [MulW-1:0] h;
        h = $signed(MulW'(1) << (s - 1));
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MulW-1:0] v);
        logic signed [MulW-1:0] hi;
        logic signed [MulW-1:0] lo;
        hi = MulW'(32'sh7fff_ffff);
        lo = MulW'(-33'sd2147483648);
        if (v > hi)
            return 32'sh7fff_ffff;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== rtl/core/kaf_mul.sv =====
// ============================================================================
// kaf_mul
// Shared signed multiplier with a registered product.
// ============================================================================
module kaf_mul
    import kaf_pkg::*;
(
    input  logic                    clk,
    input  logic signed [MulAW-1:0] a,
    input  logic signed [MulBW-1:0] b,
    output logic signed [MulW-1:0]  p
);

    logic signed [MulW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MulW'(a) * MulW'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/kaf_div.sv =====
// ============================================================================
// kaf_div
// Radix-2 restoring divider for the gains: sat32((p * 2^30) / den),
// truncated toward zero, one quotient bit per cycle.
// ============================================================================
module kaf_div
    import kaf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [31:0]        den,
    output logic               done,
    output logic signed [31:0] q
);

    logic               busy_reg;
    logic               done_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic [31:0]        rem_reg;
    logic [DivQW-1:0]   nq_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;

    logic [32:0]        rs;
    logic               qbit;
    logic [32:0]        diff;
    logic [31:0]        mag;

    always_comb
    begin
        rs   = {rem_reg, nq_reg[DivQW-1]};
        diff = rs - {1'b0, den_reg};
        qbit = (rs >= {1'b0, den_reg});
        mag  = num[31] ? 32'(-num) : 32'(num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                nq_reg   <= {mag, 30'b0};
                den_reg  <= den;
                neg_reg  <= num[31];
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[31:0] : rs[31:0];
                nq_reg  <= {nq_reg[DivQW-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DivCntW'(DivQW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
            q = (nq_reg > DivQW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-nq_reg[31:0]);
        else
            q = (nq_reg > DivQW'(64'h7fff_ffff)) ? 32'sh7fff_ffff : nq_reg[31:0];
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/kalman_angle_filter.sv =====
// ============================================================================
// kalman_angle_filter
// Two-state Kalman filter (tilt angle, gyro bias) in fixed point, built
// around one shared multiplier and one bit-serial divider.
//
//   channel   dir  beat content
//   s_axis    in   angle_meas, rate_meas, sample_interval
//   m_axis    out  angle_est, bias_est
//   apb       in   angle_noise @0x0, bias_noise @0x4, measure_noise @0x8
//
// When S is positive, an item runs through ten multiply steps on the
// registered shared multiplier plus two gain divisions of 62 quotient bits
// each, one after the other. With S not positive the divisions are skipped.
// s_axis_tready is high only while the sequencer idles; one finished beat
// waits in the output register without blocking the next item's intake.
// The sequencer stalls in its last step while that register is still full.
// Reset clears the state, covariance and noise registers to defaults.
// ============================================================================
module kalman_angle_filter
    import kaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // angle_meas[24:0], rate_meas[56:25],
                                        // sample_interval[73:57], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // angle_est[31:0], bias_est[63:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_S, ST_D0W, ST_D1W,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_FIN
    } state_t;

    state_t state_reg;

    logic [NoiseW-1:0]  angle_noise_reg;
    logic [NoiseW-1:0]  bias_noise_reg;
    logic [NoiseW-1:0]  measure_noise_reg;

    logic signed [31:0] angle_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] o00_reg, o01_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [24:0] meas_reg;
    logic signed [31:0] rate_reg;
    logic [16:0]        dt_reg;
    logic signed [33:0] dtp11_reg;
    logic signed [32:0] y_reg;

    logic               out_valid_reg;
    logic [63:0]        out_data_reg;

    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [MulW-1:0]  prod;
    logic signed [MulW-1:0]  r16, r30;
    logic signed [MulAW-1:0] dt_op;
    logic signed [34:0]      t_val;
    logic signed [33:0]      s_val;
    logic signed [32:0]      y_val;

    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_q;

    logic               wr_en;

    kaf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    kaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_val[31:0]),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        dt_op = $signed({16'b0, dt_reg});
        r16   = rnd_shr(prod, 16);
        r30   = rnd_shr(prod, 30);
        t_val = 35'(dtp11_reg) - 35'(p01_reg) - 35'(p10_reg)
              + $signed({5'b0, angle_noise_reg});
        s_val = 34'(p00_reg) + $signed({4'b0, measure_noise_reg});
        y_val = 33'(meas_reg) - 33'(angle_reg);

        mul_a = dt_op;
        mul_b = '0;
        unique case (state_reg)
            ST_M1:   mul_b = MulBW'(33'(rate_reg) - 33'(bias_reg));
            ST_M2:   mul_b = MulBW'(p11_reg);
            ST_M3:
            begin
                mul_a = $signed({3'b0, bias_noise_reg});
                mul_b = MulBW'($signed({16'b0, dt_reg}));
            end
            ST_M4:   mul_b = MulBW'(t_val);
            ST_C1:
            begin
                mul_a = MulAW'(k0_reg);
                mul_b = MulBW'(y_val);
            end
            ST_C2:
            begin
                mul_a = MulAW'(k1_reg);
                mul_b = MulBW'(y_reg);
            end
            ST_C3:
            begin
                mul_a = MulAW'(k0_reg);
                mul_b = MulBW'(p00_reg);
            end
            ST_C4:
            begin
                mul_a = MulAW'(k0_reg);
                mul_b = MulBW'(o01_reg);
            end
            ST_C5:
            begin
                mul_a = MulAW'(k1_reg);
                mul_b = MulBW'(o00_reg);
            end
            ST_C6:
            begin
                mul_a = MulAW'(k1_reg);
                mul_b = MulBW'(o01_reg);
            end
            default: mul_b = '0;
        endcase

        div_start = ((state_reg == ST_S) && (s_val > 34'sd0))
                 || ((state_reg == ST_D0W) && div_done);
        div_num   = (state_reg == ST_S) ? p00_reg : p10_reg;
    end

    assign wr_en         = psel && penable && pwrite;
    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ANGLE_NOISE:   prdata = {2'b0, angle_noise_reg};
            REG_BIAS_NOISE:    prdata = {2'b0, bias_noise_reg};
            REG_MEASURE_NOISE: prdata = {2'b0, measure_noise_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            angle_reg         <= '0;
            bias_reg          <= '0;
            p00_reg           <= '0;
            p01_reg           <= '0;
            p10_reg           <= '0;
            p11_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (paddr[3:2])
                    REG_ANGLE_NOISE:   angle_noise_reg   <= pwdata[NoiseW-1:0];
                    REG_BIAS_NOISE:    bias_noise_reg    <= pwdata[NoiseW-1:0];
                    REG_MEASURE_NOISE: measure_noise_reg <= pwdata[NoiseW-1:0];
                    default:           ;
                endcase
            end

            if ((state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        meas_reg  <= s_axis_tdata[24:0];
                        rate_reg  <= s_axis_tdata[56:25];
                        dt_reg    <= s_axis_tdata[73:57];
                        state_reg <= ST_M1;
                    end
                end
                ST_M1: state_reg <= ST_M2;
                ST_M2:
                begin
                    angle_reg <= sat32(MulW'(angle_reg) + r16);
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    dtp11_reg <= r16[33:0];
                    state_reg <= ST_M4;
                end
                ST_M4:
                begin
                    // t was formed from the old P01/P10 this cycle
                    p11_reg   <= sat32(MulW'(p11_reg) + r16);
                    p01_reg   <= sat32(MulW'(p01_reg) - MulW'(dtp11_reg));
                    p10_reg   <= sat32(MulW'(p10_reg) - MulW'(dtp11_reg));
                    state_reg <= ST_M5;
                end
                ST_M5:
                begin
                    p00_reg   <= sat32(MulW'(p00_reg) + r16);
                    state_reg <= ST_S;
                end
                ST_S:
                begin
                    // non-positive S: zero gains, correction drops out
                    if (s_val > 34'sd0)
                        state_reg <= ST_D0W;
                    else
                    begin
                        k0_reg    <= '0;
                        k1_reg    <= '0;
                        state_reg <= ST_C1;
                    end
                end
                ST_D0W:
                begin
                    if (div_done)
                    begin
                        k0_reg    <= div_q;
                        state_reg <= ST_D1W;
                    end
                end
                ST_D1W:
                begin
                    if (div_done)
                    begin
                        k1_reg    <= div_q;
                        state_reg <= ST_C1;
                    end
                end
                ST_C1:
                begin
                    y_reg     <= y_val;
                    state_reg <= ST_C2;
                end
                ST_C2:
                begin
                    angle_reg <= sat32(MulW'(angle_reg) + r30);
                    state_reg <= ST_C3;
                end
                ST_C3:
                begin
                    bias_reg  <= sat32(MulW'(bias_reg) + r30);
                    o00_reg   <= p00_reg;
                    o01_reg   <= p01_reg;
                    state_reg <= ST_C4;
                end
                ST_C4:
                begin
                    p00_reg   <= sat32(MulW'(o00_reg) - r30);
                    state_reg <= ST_C5;
                end
                ST_C5:
                begin
                    p01_reg   <= sat32(MulW'(o01_reg) - r30);
                    state_reg <= ST_C6;
                end
                ST_C6:
                begin
                    p10_reg   <= sat32(MulW'(p10_reg) - r30);
                    state_reg <= ST_C7;
                end
                ST_C7:
                begin
                    p11_reg   <= sat32(MulW'(p11_reg) - r30);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= {bias_reg, angle_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: angle/bias Kalman filter testbench
// Streams measurement beats into the filter, predicts each filtered angle and
// bias with an independent fixed-point model and compares every output beat.
// Noise registers are rewritten over APB between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top
    import kaf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [16:0] dt;
        logic [31:0] rate;
        logic [24:0] meas;
    } meas_beat_t;

    typedef struct packed {
        logic [31:0] bias;
        logic [31:0] angle;
    } est_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kalman_angle_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter model state
    logic [29:0]        q_angle;
    logic [29:0]        q_bias;
    logic [29:0]        r_meas;
    logic signed [31:0] x_angle;
    logic signed [31:0] x_bias;
    logic signed [31:0] cov [4];

    meas_beat_t  pending_beats [$];
    est_beat_t   expected_est [$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    logic        s_axis_tready_q;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Signed 64x64 product reduced with rounding; products here can exceed
    // 64 bits only when saturation follows anyway, so use 128-bit math.
    function automatic longint mul_round(longint a, longint b, int s);
        logic signed [127:0] p;
        logic signed [127:0] r;
        p = 128'(signed'(a)) * 128'(signed'(b));
        r = (p + (128'sd1 <<< (s - 1))) >>> s;
        if (r > 128'sd9223372036854775807)
            return 64'sd9223372036854775807;
        if (r < -128'sd9223372036854775807)
            return -64'sd9223372036854775807;
        return longint'(r);
    endfunction

    task automatic predict_estimate(input meas_beat_t b);
        longint meas, rate, dt, p00, p01, p10, p11, dtp11, t, s, k0, k1, y, o00, o01;
        meas = longint'(signed'(b.meas));
        rate = longint'(signed'(b.rate));
        dt = longint'({47'd0, b.dt});
        x_angle = 32'(clamp32(longint'(x_angle) +
                  mul_round(dt, rate - longint'(x_bias), 16)));
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        dtp11 = mul_round(dt, p11, 16);
        t = dtp11 - p01 - p10 + longint'(q_angle);
        p00 = clamp32(p00 + mul_round(dt, t, 16));
        p01 = clamp32(p01 - dtp11);
        p10 = clamp32(p10 - dtp11);
        p11 = clamp32(p11 + mul_round(longint'(q_bias), dt, 16));
        s = p00 + longint'(r_meas);
        if (s > 0)
        begin
            k0 = clamp32((p00 <<< 30) / s);
            k1 = clamp32((p10 <<< 30) / s);
        end
        else
        begin
            k0 = 0;
            k1 = 0;
        end
        y = meas - longint'(x_angle);
        x_angle = 32'(clamp32(longint'(x_angle) + mul_round(k0, y, 30)));
        x_bias = 32'(clamp32(longint'(x_bias) + mul_round(k1, y, 30)));
        o00 = p00;
        o01 = p01;
        cov[0] = 32'(clamp32(o00 - mul_round(k0, o00, 30)));
        cov[1] = 32'(clamp32(o01 - mul_round(k0, o01, 30)));
        cov[2] = 32'(clamp32(p10 - mul_round(k1, o00, 30)));
        cov[3] = 32'(clamp32(p11 - mul_round(k1, o01, 30)));
        expected_est.push_back('{bias: x_bias, angle: x_angle});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // driver: model is updated as each beat is accepted
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready_q)
            begin
                predict_estimate(pending_beats.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready_q) && pending_beats.size() > 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, pending_beats[0]};
            end
            else if (!s_axis_tvalid || s_axis_tready_q)
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off counted here, random idling otherwise
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // sampled acceptance of the input beat at the rising edge
    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    end

    // monitor
    always @(posedge clk)
    begin
        est_beat_t got;
        est_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_est.size() == 0)
            begin
                report_mismatch("unexpected beat angle_est", got.angle, '0);
            end
            else
            begin
                want = expected_est.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch("angle_est", got.angle, want.angle);
                if (got.bias !== want.bias)
                    report_mismatch("bias_est", got.bias, want.bias);
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE:   q_angle = value[29:0];
            REG_BIAS_NOISE:    q_bias = value[29:0];
            REG_MEASURE_NOISE: r_meas = value[29:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || expected_est.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic meas_beat_t rand_beat();
        meas_beat_t b;
        int mode;
        mode = $urandom_range(9);
        b.meas = (mode == 0) ? 25'($urandom) :
                 25'(int'($urandom_range(23592960)) - 11796480);
        b.rate = (mode == 1) ? $urandom :
                 32'(int'($urandom_range(2 * 19660800)) - 19660800);
        b.dt = (mode == 2) ? 17'($urandom) : 17'($urandom_range(1311, 65536));
        return b;
    endfunction

    task automatic push_beat(input logic [24:0] m, input logic [31:0] r,
                             input logic [16:0] d);
        pending_beats.push_back('{dt: d, rate: r, meas: m});
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off = 0;
        send_idle_pct = 20;
        recv_idle_pct = 81;
        q_angle = ANGLE_NOISE_RST;
        q_bias = BIAS_NOISE_RST;
        r_meas = MEASURE_NOISE_RST;
        x_angle = 0;
        x_bias = 0;
        for (int i = 0; i < 4; i++)
            cov[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes at reset defaults
        push_beat(25'd0, 32'd0, 17'd0);
        push_beat(25'h0B40000, 32'h7fffffff, 17'd65536);
        push_beat(25'h14C0000, 32'h80000000, 17'd65536);
        push_beat(25'h0FFFFFF, 32'h80000000, 17'h1FFFF);
        push_beat(25'h1000000, 32'h7fffffff, 17'h1FFFF);
        push_beat(25'h1FFFFFF, 32'hffffffff, 17'd1);
        push_beat(25'd0, 32'd0, 17'd655);
        drain();

        // zero measurement noise and extreme process noise
        apb_write(REG_MEASURE_NOISE, 32'd0);
        apb_write(REG_ANGLE_NOISE, 32'h3fffffff);
        apb_write(REG_BIAS_NOISE, 32'h3fffffff);
        for (int i = 0; i < 6; i++)
            push_beat(25'($urandom), $urandom, 17'($urandom));
        push_beat(25'h0B40000, 32'h7fffffff, 17'h1FFFF);
        push_beat(25'h14C0000, 32'h80000000, 17'h1FFFF);
        drain();

        apb_write(REG_ANGLE_NOISE, 32'd0);
        apb_write(REG_BIAS_NOISE, 32'd0);
        apb_write(REG_MEASURE_NOISE, 32'h3fffffff);
        for (int i = 0; i < 6; i++)
            push_beat(25'($urandom), $urandom, 17'($urandom));
        drain();

        // random phases with different noise settings and idling
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 20;
            end
            if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apb_write(REG_ANGLE_NOISE, (ph == 2) ? 32'd107374 : $urandom_range(1 << 22));
            apb_write(REG_BIAS_NOISE, (ph == 2) ? 32'd429497 : $urandom_range(1 << 22));
            apb_write(REG_MEASURE_NOISE, $urandom_range(1, 1 << 26));
            for (int i = 0; i < 475; i++)
                pending_beats.push_back(rand_beat());
            if (ph == 2)
                hold_off = 2000;
            drain();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
